// File: rtl/core/base38_text_decoder_unit_defines.svh
// Assertion macros for the base38 text decoder.
// In synthesis builds the macros expand to nothing.
`ifndef BASE38_TEXT_DECODER_UNIT_DEFINES_SVH
`define BASE38_TEXT_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside of reset.
`define B38D_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("b38d: assertion failed");

// Checks a property on every rising clock edge, reset included.
`define B38D_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("b38d: assertion failed");

`else

`define B38D_ASSERT(lbl, clk, rst, prop)
`define B38D_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/core/b38d_pkg.sv
package b38d_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_CHAR    = 2'd1,
      STATUS_AFTER_SPACE = 2'd2,
      STATUS_TOO_LONG    = 2'd3
   } status_type;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

   // Digit values of the alphabet ranges.
   localparam logic [5:0] DIGIT_UNDER  = 6'd0;
   localparam logic [5:0] DIGIT_NUM0   = 6'd1;
   localparam logic [5:0] DIGIT_LETTER = 6'd11;
   localparam logic [5:0] DIGIT_DASH   = 6'd37;
   localparam logic [5:0] RADIX        = 6'd38;

   // Classification of one character.
   typedef struct packed {
      logic       is_nul;
      logic       is_space;
      logic       is_under;
      logic       is_digit;
      logic [5:0] digit;
   } char_info_type;

   // Register file layout.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0]  REG_MAX_OUTPUT_BYTES = 1'b0;
   localparam logic [6:0]  MAX_OUTPUT_RESET = 7'd64;

endpackage

// File: rtl/core/b38d_req_if.sv
interface b38d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/core/b38d_rsp_if.sv
interface b38d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_present;
   logic       last_result;
   logic [1:0] status;

   modport source (output valid, output out_byte, output byte_present, output last_result,
                   output status, input ready);
   modport sink (input valid, input out_byte, input byte_present, input last_result,
                 input status, output ready);
endinterface

// File: rtl/core/b38d_char_class.sv
module b38d_char_class (
   input  logic [7:0]             char_code,
   output b38d_pkg::char_info_type info
);

   // Sort the character into the alphabet, whitespace and the rest.
   always_comb begin
      info          = '0;
      info.is_nul   = (char_code == b38d_pkg::CHAR_NUL);
      info.is_space = (char_code == b38d_pkg::CHAR_SPACE) ||
                      (char_code inside {[b38d_pkg::CHAR_TAB : b38d_pkg::CHAR_CR]});
      info.is_under = (char_code == b38d_pkg::CHAR_UNDER);
      case (1'b1)
         (char_code == b38d_pkg::CHAR_UNDER): begin
            info.is_digit = 1'b1;
            info.digit    = b38d_pkg::DIGIT_UNDER;
         end
         (char_code inside {[b38d_pkg::CHAR_ZERO : b38d_pkg::CHAR_NINE]}): begin
            info.is_digit = 1'b1;
            info.digit    = 6'(char_code - b38d_pkg::CHAR_ZERO) + b38d_pkg::DIGIT_NUM0;
         end
         (char_code inside {[b38d_pkg::CHAR_LOW_A : b38d_pkg::CHAR_LOW_Z]}): begin
            info.is_digit = 1'b1;
            info.digit    = 6'(char_code - b38d_pkg::CHAR_LOW_A) + b38d_pkg::DIGIT_LETTER;
         end
         (char_code == b38d_pkg::CHAR_DASH): begin
            info.is_digit = 1'b1;
            info.digit    = b38d_pkg::DIGIT_DASH;
         end
         default: begin
            info.is_digit = 1'b0;
            info.digit    = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/b38d_num_ram.sv
module b38d_num_ram #(
   parameter int unsigned DEPTH  = 65,
   parameter int unsigned ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data_ff
);

   logic [7:0] mem_ff [DEPTH];

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // One registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// File: rtl/core/b38d_csr.sv
module b38d_csr #(
   parameter int unsigned MAX_BYTES = 64,
   parameter int unsigned LEN_W     = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [b38d_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic [LEN_W-1:0]                limit
);

   logic [6:0] max_out_ff;
   logic [6:0] max_out_in;
   logic       sel_max;

   assign sel_max = (paddr[b38d_pkg::CSR_ADDR_W-1:2] == b38d_pkg::REG_MAX_OUTPUT_BYTES);

   // Register write in the access cycle.
   always_comb begin
      max_out_in = max_out_ff;
      if (psel && penable && pwrite && sel_max) begin
         max_out_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff <= b38d_pkg::MAX_OUTPUT_RESET;
      end else begin
         max_out_ff <= max_out_in;
      end
   end

   assign prdata = sel_max ? {25'd0, max_out_ff} : 32'd0;

   // The limit in force saturates at the size of the number store.
   assign limit = (max_out_ff > 7'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : LEN_W'(max_out_ff);

endmodule

// File: rtl/core/base38_text_decoder_unit.sv
// Channel  Direction  Payload
// req      in         char_code[7:0], last_char
// rsp      out        out_byte[7:0], byte_present, last_result, status[1:0]
// csr      in/out     APB write/read of max_output_bytes at byte address 0
//
// A whitespace, '_' zero or error character is handled in ST_IDLE alone. A digit walks the
// stored number one byte per cycle through the 8x6 multiply-add, via ST_DIG_START,
// ST_DIG_RUN and ST_DIG_CHECK; the new number length is at most MAX_BYTES+1.
// The last character passes through ST_FINISH, then one result per cycle while rsp is ready.
// Reset is synchronous; the number store is not cleared, bytes beyond the
// current number length read as zero. A stalled rsp holds the block in its output phase.
`include "base38_text_decoder_unit_defines.svh"

module base38_text_decoder_unit #(
   parameter int unsigned MAX_BYTES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   b38d_req_if.sink                        req_ch,
   b38d_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [b38d_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int unsigned DEPTH  = MAX_BYTES + 1;
   localparam int unsigned ADDR_W = $clog2(MAX_BYTES + 1);
   localparam int unsigned LEN_W  = $clog2(MAX_BYTES + 2);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_DIG_START = 8'b0000_0010,
      ST_DIG_RUN   = 8'b0000_0100,
      ST_DIG_CHECK = 8'b0000_1000,
      ST_FINISH    = 8'b0001_0000,
      ST_EMIT_ONE  = 8'b0010_0000,
      ST_EMIT_ZERO = 8'b0100_0000,
      ST_EMIT_BYTE = 8'b1000_0000
   } state_type;

   typedef enum logic [3:0] {
      PH_LEAD   = 4'b0001,
      PH_ZEROS  = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_TRAIL  = 4'b1000
   } phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   b38d_pkg::status_type err_ff, err_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     zeros_ff, zeros_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [5:0]           carry_ff, carry_in;
   logic                 last_ff, last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_present_ff, rsp_present_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   b38d_pkg::char_info_type info;
   logic [LEN_W-1:0]        limit;
   logic [LEN_W:0]          total;
   logic                    out_free;
   logic                    load;
   logic                    accept;

   logic                    ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]       ram_wr_addr, ram_rd_addr;
   logic [7:0]              ram_wr_data, ram_rd_data;

   logic [7:0]              cur_byte;
   logic [13:0]             mac_sum;
   logic [5:0]              mac_carry;
   logic [LEN_W-1:0]        idx_next;
   logic                    dig_more;
   logic [LEN_W-1:0]        zeros_inc;

   b38d_char_class u_class (
      .char_code (req_ch.char_code),
      .info      (info)
   );

   b38d_num_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   b38d_csr #(
      .MAX_BYTES (MAX_BYTES),
      .LEN_W     (LEN_W)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .limit   (limit)
   );

   assign csr_pready = 1'b1;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign total        = (LEN_W + 1)'(len_ff) + (LEN_W + 1)'(zeros_ff);
   assign zeros_inc    = zeros_ff + LEN_W'(1);

   // One multiply-add step: byte times the radix plus the incoming carry.
   assign cur_byte  = (LEN_W'(idx_ff) < len_ff) ? ram_rd_data : 8'd0;
   assign mac_sum   = (14'(cur_byte) * 14'(b38d_pkg::RADIX)) + 14'(carry_ff);
   assign mac_carry = mac_sum[13:8];
   assign idx_next  = LEN_W'(idx_ff) + LEN_W'(1);
   assign dig_more  = ((mac_carry != 6'd0) || (idx_next < len_ff)) &&
                      (idx_ff < ADDR_W'(MAX_BYTES));

   // Sequencer: character scan, digit walk and result output.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      err_in         = err_ff;
      len_in         = len_ff;
      zeros_in       = zeros_ff;
      idx_in         = idx_ff;
      carry_in       = carry_ff;
      last_in        = last_ff;
      load           = 1'b0;
      rsp_byte_in    = rsp_byte_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff;
      ram_wr_data    = mac_sum[7:0];
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in  = req_ch.last_char;
               state_in = req_ch.last_char ? ST_FINISH : ST_IDLE;
               if (info.is_nul) begin
                  err_in = b38d_pkg::STATUS_BAD_CHAR;
               end else if (err_ff == b38d_pkg::STATUS_OK) begin
                  case (phase_ff)
                     PH_LEAD, PH_ZEROS: begin
                        if (info.is_space) begin
                           if (phase_ff == PH_ZEROS) begin
                              phase_in = PH_TRAIL;
                           end
                        end else if (info.is_under) begin
                           phase_in = PH_ZEROS;
                           zeros_in = zeros_inc;
                           if (zeros_inc > limit) begin
                              err_in = b38d_pkg::STATUS_TOO_LONG;
                           end
                        end else begin
                           phase_in = PH_DIGITS;
                           if (info.is_digit) begin
                              carry_in = info.digit;
                              state_in = ST_DIG_START;
                           end else begin
                              err_in = b38d_pkg::STATUS_BAD_CHAR;
                           end
                        end
                     end
                     PH_DIGITS: begin
                        if (info.is_space) begin
                           phase_in = PH_TRAIL;
                        end else if (info.is_digit) begin
                           carry_in = info.digit;
                           state_in = ST_DIG_START;
                        end else begin
                           err_in = b38d_pkg::STATUS_BAD_CHAR;
                        end
                     end
                     default: begin
                        if (!info.is_space) begin
                           err_in = b38d_pkg::STATUS_AFTER_SPACE;
                        end
                     end
                  endcase
               end
            end
         end

         ST_DIG_START: begin
            // A zero digit into an empty number leaves it empty.
            if ((carry_ff == 6'd0) && (len_ff == '0)) begin
               state_in = ST_DIG_CHECK;
            end else begin
               idx_in      = '0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = ST_DIG_RUN;
            end
         end

         ST_DIG_RUN: begin
            // Write back this byte and fetch the next one ahead of use.
            ram_wr_en = 1'b1;
            carry_in  = mac_carry;
            if (dig_more) begin
               idx_in      = idx_ff + ADDR_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + ADDR_W'(1);
            end else begin
               len_in   = idx_next;
               state_in = ST_DIG_CHECK;
            end
         end

         ST_DIG_CHECK: begin
            if (total > (LEN_W + 1)'(limit)) begin
               err_in = b38d_pkg::STATUS_TOO_LONG;
            end
            state_in = last_ff ? ST_FINISH : ST_IDLE;
         end

         ST_FINISH: begin
            if ((err_ff != b38d_pkg::STATUS_OK) || (total == '0)) begin
               state_in = ST_EMIT_ONE;
            end else if (zeros_ff != '0) begin
               state_in = ST_EMIT_ZERO;
            end else begin
               idx_in      = ADDR_W'(len_ff - LEN_W'(1));
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(len_ff - LEN_W'(1));
               state_in    = ST_EMIT_BYTE;
            end
         end

         ST_EMIT_ONE: begin
            if (out_free) begin
               load           = 1'b1;
               rsp_byte_in    = 8'd0;
               rsp_present_in = 1'b0;
               rsp_last_in    = 1'b1;
               rsp_status_in  = err_ff;
               state_in       = ST_IDLE;
            end
         end

         ST_EMIT_ZERO: begin
            if (out_free) begin
               load           = 1'b1;
               rsp_byte_in    = 8'd0;
               rsp_present_in = 1'b1;
               rsp_last_in    = (zeros_ff == LEN_W'(1)) && (len_ff == '0);
               rsp_status_in  = b38d_pkg::STATUS_OK;
               zeros_in       = zeros_ff - LEN_W'(1);
               if (zeros_ff == LEN_W'(1)) begin
                  if (len_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in      = ADDR_W'(len_ff - LEN_W'(1));
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_W'(len_ff - LEN_W'(1));
                     state_in    = ST_EMIT_BYTE;
                  end
               end
            end
         end

         ST_EMIT_BYTE: begin
            // Most significant byte first, one per cycle while the output is free.
            if (out_free) begin
               load           = 1'b1;
               rsp_byte_in    = ram_rd_data;
               rsp_present_in = 1'b1;
               rsp_last_in    = (idx_ff == '0);
               rsp_status_in  = b38d_pkg::STATUS_OK;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in      = idx_ff - ADDR_W'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff - ADDR_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The final result of a text clears the text state.
      if (load && rsp_last_in) begin
         phase_in = PH_LEAD;
         err_in   = b38d_pkg::STATUS_OK;
         len_in   = '0;
         zeros_in = '0;
      end
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LEAD;
         err_ff       <= b38d_pkg::STATUS_OK;
         len_ff       <= '0;
         zeros_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         len_ff       <= len_in;
         zeros_ff     <= zeros_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and output payload registers.
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      carry_ff       <= carry_in;
      last_ff        <= last_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = rsp_byte_ff;
   assign rsp_ch.byte_present = rsp_present_ff;
   assign rsp_ch.last_result  = rsp_last_ff;
   assign rsp_ch.status       = rsp_status_ff;

   // A byte result is always an ok result.
   `B38D_ASSERT(a_byte_ok, clock, reset, (rsp_ch.valid && rsp_ch.byte_present) |-> (rsp_ch.status == b38d_pkg::STATUS_OK))
   // An empty or error result always ends its text.
   `B38D_ASSERT(a_empty_last, clock, reset, (rsp_ch.valid && !rsp_ch.byte_present) |-> rsp_ch.last_result)
   // The digit walk stays inside the number store.
   `B38D_ASSERT(a_walk_bound, clock, reset, (state_ff == ST_DIG_RUN) |-> (idx_ff <= ADDR_W'(MAX_BYTES)))
   // Output of an ok text never exceeds the store size.
   `B38D_ASSERT(a_emit_bound, clock, reset, ((state_ff == ST_EMIT_ZERO) || (state_ff == ST_EMIT_BYTE)) |-> (total <= (LEN_W + 1)'(MAX_BYTES)))

endmodule

// File: sim/b38d_decode_checker.sv
// Watches the character, result and register ports of the base38 decoder,
// predicts every result item and compares it with what the block delivers.
module b38d_decode_checker
   import b38d_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   b38d_req_if                   req_ch,
   b38d_rsp_if                   rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic [31:0]           csr_prdata,
   input  logic                  csr_pready,
   output int unsigned           fail_count,
   output int unsigned           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Where the scan of one text currently stands.
   typedef enum logic [1:0] {
      SCAN_LEAD,
      SCAN_ZEROS,
      SCAN_DIGITS,
      SCAN_TRAIL
   } scan_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       last_result;
      status_type status;
   } decoded_result_type;

   // Shadow of the register and of the decoding state of the current text.
   logic [6:0]         max_bytes_reg;
   logic [7:0]         number_store [0:MAX_BYTES];
   int unsigned        number_len;
   int unsigned        zero_count;
   scan_phase_type     scan;
   status_type         text_error;
   decoded_result_type expected_q [$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: decoder mismatch: %s", $time, what);
      fail_count++;
   endtask

   // Appends one predicted result item at the tail of the queue.
   task automatic queue_result(input decoded_result_type r);
      expected_q.insert(expected_q.size(), r);
   endtask

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // Value of an alphabet character, or the radix itself for anything else.
   function automatic int unsigned digit_value(input logic [7:0] c);
      if (c == CHAR_UNDER) return DIGIT_UNDER;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return DIGIT_NUM0 + (c - CHAR_ZERO);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) return DIGIT_LETTER + (c - CHAR_LOW_A);
      if (c == CHAR_DASH) return DIGIT_DASH;
      return RADIX;
   endfunction

   // The register saturates at the size of the number store.
   function automatic int unsigned byte_limit();
      return (max_bytes_reg > MAX_BYTES) ? MAX_BYTES : max_bytes_reg;
   endfunction

   task automatic clear_text();
      foreach (number_store[i]) number_store[i] = 8'h00;
      number_len = 0;
      zero_count = 0;
      scan = SCAN_LEAD;
      text_error = STATUS_OK;
   endtask

   // Multiplies the stored number by the radix and adds one digit.
   task automatic add_digit(input logic [7:0] c);
      int unsigned carry;
      int unsigned idx;
      carry = digit_value(c);
      idx = 0;
      if (carry >= RADIX) begin
         text_error = STATUS_BAD_CHAR;
         return;
      end
      while ((carry != 0 || idx < number_len) && idx < MAX_BYTES + 1) begin
         carry = carry + int'(RADIX) * int'(number_store[idx]);
         number_store[idx] = carry[7:0];
         carry = carry >> 8;
         idx++;
      end
      number_len = idx;
      if (number_len + zero_count > byte_limit()) text_error = STATUS_TOO_LONG;
   endtask

   task automatic count_zero();
      scan = SCAN_ZEROS;
      zero_count++;
      if (zero_count > byte_limit()) text_error = STATUS_TOO_LONG;
   endtask

   // A NUL always wins; once an error is set nothing else is decoded.
   task automatic scan_char(input logic [7:0] c);
      if (c == CHAR_NUL) begin
         text_error = STATUS_BAD_CHAR;
         return;
      end
      if (text_error != STATUS_OK) return;
      case (scan)
         SCAN_LEAD, SCAN_ZEROS: begin
            if (is_blank(c)) begin
               if (scan == SCAN_ZEROS) scan = SCAN_TRAIL;
            end else if (c == CHAR_UNDER) begin
               count_zero();
            end else begin
               scan = SCAN_DIGITS;
               add_digit(c);
            end
         end
         SCAN_DIGITS: begin
            if (is_blank(c)) scan = SCAN_TRAIL;
            else add_digit(c);
         end
         default: begin
            if (!is_blank(c)) text_error = STATUS_AFTER_SPACE;
         end
      endcase
   endtask

   // On the last character: an error or empty result alone, else the zero bytes, then the number from the top byte.
   task automatic finish_text();
      decoded_result_type res;
      int unsigned total;
      int unsigned idx;
      res = '{out_byte: 8'h00, byte_present: 1'b0, last_result: 1'b1, status: STATUS_OK};
      total = zero_count + number_len;
      if (text_error != STATUS_OK) begin
         res.status = text_error;
         queue_result(res);
      end else if (total == 0) begin
         queue_result(res);
      end else begin
         if (total > MAX_BYTES) total = MAX_BYTES;
         for (int unsigned k = 0; k < total; k++) begin
            res.byte_present = 1'b1;
            res.last_result = (k == total - 1);
            if (k < zero_count) begin
               res.out_byte = 8'h00;
            end else begin
               idx = number_len - 1 - (k - zero_count);
               if (idx > MAX_BYTES) idx = MAX_BYTES;
               res.out_byte = number_store[idx];
            end
            queue_result(res);
         end
      end
      clear_text();
   endtask

   task automatic compare_result();
      decoded_result_type want;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result byte %02h present %0b last %0b status %0d",
            rsp_ch.out_byte, rsp_ch.byte_present, rsp_ch.last_result, rsp_ch.status));
         return;
      end
      want = expected_q.pop_front();
      if (rsp_ch.out_byte !== want.out_byte)
         report_mismatch($sformatf("out_byte %02h, expected %02h", rsp_ch.out_byte,
            want.out_byte));
      if (rsp_ch.byte_present !== want.byte_present)
         report_mismatch($sformatf("byte_present %0b, expected %0b", rsp_ch.byte_present,
            want.byte_present));
      if (rsp_ch.last_result !== want.last_result)
         report_mismatch($sformatf("last_result %0b, expected %0b", rsp_ch.last_result,
            want.last_result));
      if (rsp_ch.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
   endtask

   // Everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (reset) begin
         max_bytes_reg = MAX_OUTPUT_RESET;
         clear_text();
         expected_q.delete();
      end else begin
         // Register port: writes update the shadow, reads are compared with it.
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == REG_MAX_OUTPUT_BYTES) begin
            if (csr_pwrite) begin
               max_bytes_reg = csr_pwdata[6:0];
            end else if (csr_prdata !== {25'd0, max_bytes_reg}) begin
               report_mismatch($sformatf("max_output_bytes read %08h, expected %08h",
                  csr_prdata, {25'd0, max_bytes_reg}));
            end
         end

         if (rsp_ch.valid && rsp_ch.ready) compare_result();

         if (req_ch.valid && req_ch.ready) begin
            scan_char(req_ch.char_code);
            if (req_ch.last_char) finish_text();
         end
      end
      pending = expected_q.size();
   end
endmodule

// File: sim/testbench.sv
// Drives base38 texts and register settings into the decoder under several
// idle patterns; the checker beside the block predicts and compares results.
module testbench;
   import b38d_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_BYTES = 64;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned ITEMS_PER_PHASE = 26;
   localparam logic [CSR_ADDR_W-1:0] MAX_BYTES_ADDR = {REG_MAX_OUTPUT_BYTES, 2'b00};
   // Word address with no register behind it.
   localparam logic [CSR_ADDR_W-1:0] SPARE_REG_ADDR = 3'h4;

   typedef logic [7:0] char_q_type [$];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int unsigned           fail_count;
   int unsigned           pending_results;
   int unsigned           send_idle_pct = 0;
   int unsigned           rsp_stall_pct = 0;
   int unsigned           items_sent = 0;
   char_q_type            text_q;
   string                 alphabet = "_0123456789abcdefghijklmnopqrstuvwxyz-";

   b38d_req_if req_ch ();
   b38d_rsp_if rsp_ch ();

   base38_text_decoder_unit #(
      .MAX_BYTES (MAX_BYTES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   b38d_decode_checker #(
      .MAX_BYTES (MAX_BYTES)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The result side stalls at random according to the current phase.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Ends the run when nothing at all is accepted for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_psel && csr_penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [7:0] pick_digit();
      return alphabet[$urandom_range(alphabet.len() - 1)];
   endfunction

   // Space, or one of TAB, LF, VT, FF and CR.
   function automatic logic [7:0] pick_blank();
      int unsigned k;
      k = $urandom_range(5);
      return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
   endfunction

   // Adds one character at the end of the text being composed.
   task automatic append_char(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endtask

   // One character item; valid stays up afterwards until the next call.
   task automatic send_char(input logic [7:0] c, input logic is_final);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.char_code <= c;
      req_ch.last_char <= is_final;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_chars(input char_q_type chars);
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
   endtask

   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [6:0] value);
      logic [31:0] word;
      word = $urandom;
      word[6:0] = value;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= addr;
      csr_pwdata <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Drops valid, waits for every expected result, then lets the block drain.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed texts with random content, plus broken and noisy ones.
   task automatic compose_text();
      int unsigned kind;
      int unsigned count;
      int unsigned spot;
      logic [7:0]  junk;
      text_q.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
         count = $urandom_range(1, 5);
         repeat (count) append_char(8'($urandom_range(255)));
      end else if (kind < 15) begin
         // Long zero runs cross the limit near its top.
         count = $urandom_range(1, 70);
         repeat ($urandom_range(2)) append_char(pick_blank());
         repeat (count) append_char(CHAR_UNDER);
      end else if (kind < 20) begin
         // Long numbers can fill the whole store.
         count = $urandom_range(60, 100);
         repeat ($urandom_range(1)) append_char(pick_blank());
         repeat (count) append_char(pick_digit());
      end else begin
         repeat ($urandom_range(2)) append_char(pick_blank());
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) append_char(CHAR_UNDER);
         count = ($urandom_range(4) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
         repeat (count) append_char(pick_digit());
         repeat ($urandom_range(2)) append_char(pick_blank());
         if (kind >= 85) begin
            append_char(pick_blank());
            append_char(pick_digit());
         end else if (kind >= 70) begin
            case ($urandom_range(2))
               0: junk = CHAR_NUL;
               1: junk = 8'($urandom_range(CHAR_LOW_A - 8'h20, CHAR_LOW_Z - 8'h20));
               default: junk = 8'($urandom_range(255));
            endcase
            spot = $urandom_range(text_q.size());
            text_q.insert(spot, junk);
         end
      end
      if (text_q.size() == 0) append_char(pick_blank());
   endtask

   initial begin
      logic [6:0]  phase_limit [8];
      int unsigned phase_goal;
      phase_limit = '{7'd127, 7'd0, 7'd64, 7'd5, 7'd30, 7'd100, 7'd1, 7'd64};
      req_ch.valid = 1'b0;
      req_ch.char_code = 8'h00;
      req_ch.last_char = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = 32'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed texts at the reset limit.
      send_chars('{CHAR_UNDER});
      send_chars('{CHAR_DASH});
      send_chars('{CHAR_SPACE});
      send_chars('{CHAR_NUL});
      send_chars('{CHAR_LOW_A - 8'h20});
      send_chars('{8'hFF});
      send_chars('{CHAR_TAB + 8'd2, CHAR_UNDER, CHAR_LOW_A, CHAR_CR - 8'd1});
      send_chars('{CHAR_NINE, CHAR_SPACE, CHAR_NINE});
      send_chars('{CHAR_NINE, CHAR_SPACE, CHAR_NINE, CHAR_NUL});
      send_chars('{CHAR_LOW_Z, CHAR_LOW_Z});
      send_chars('{CHAR_ZERO, CHAR_UNDER});
      settle();

      // A one-byte limit; a write to the empty address must leave it alone.
      csr_access(1'b1, MAX_BYTES_ADDR, 7'd1);
      csr_access(1'b1, SPARE_REG_ADDR, 7'h7F);
      csr_access(1'b0, MAX_BYTES_ADDR, 7'd0);
      send_chars('{CHAR_UNDER, CHAR_UNDER});
      send_chars('{CHAR_LOW_Z, CHAR_LOW_Z});
      send_chars('{CHAR_UNDER, CHAR_ZERO});
      settle();

      // Random phases, each with its own limit and idle pattern.
      foreach (phase_limit[p]) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 55; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 55; end
            default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         csr_access(1'b1, MAX_BYTES_ADDR, phase_limit[p]);
         csr_access(1'b0, MAX_BYTES_ADDR, 7'd0);
         phase_goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_goal) begin
            compose_text();
            send_chars(text_q);
         end
         settle();
      end

      @(negedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
